@@ rtl/lqrsv_pkg.sv @@
// Shared types, constants and gain table for the LQR velocity step unit.
// Used by the top level, the shared multiplier and the port checker.
`default_nettype none

package lqrsv_pkg;

    // Number formats
    localparam int FRAC_BITS = 24;
    localparam int DT_BITS   = 24;
    localparam int STATE_W   = 32;
    localparam int TICK_W    = 24;
    localparam int LIMIT_W   = 26;
    localparam int XREF_W    = 27;
    localparam int VEL_W     = 27;
    localparam int COUPLING  = 15;

    // Datapath widths
    localparam int GAIN_W  = FRAC_BITS + 5;
    localparam int MUL_A_W = STATE_W + 1;
    localparam int PROD_W  = MUL_A_W + GAIN_W;
    localparam int ACC_W   = 64;
    localparam int RATE_W  = 40;
    localparam int SPLIT_W = 20;
    localparam int HI_W    = RATE_W - SPLIT_W;
    localparam int SUM_W   = RATE_W + 1;

    // Port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Plant state elements
    localparam int NUM_ELEM = 6;
    localparam int ELEM_W   = 3;
    localparam logic [ELEM_W-1:0] ELEM_X_POS = 3'd0;
    localparam logic [ELEM_W-1:0] ELEM_Y_POS = 3'd1;
    localparam logic [ELEM_W-1:0] ELEM_X_VEL = 3'd2;
    localparam logic [ELEM_W-1:0] ELEM_Y_VEL = 3'd3;
    localparam logic [ELEM_W-1:0] ELEM_X_INT = 3'd4;
    localparam logic [ELEM_W-1:0] ELEM_Y_INT = 3'd5;
    localparam logic [ELEM_W-1:0] LAST_ELEM  = ELEM_Y_INT;
    localparam logic [ELEM_W-1:0] LAST_STEP  = ELEM_W'(NUM_ELEM - 1);

    // Register reset values
    localparam logic [LIMIT_W-1:0]       LIMIT_RESET = LIMIT_W'(8388608);
    localparam logic signed [XREF_W-1:0] XREF_RESET  = XREF_W'(3355443);

    // Gains: values to four decimal places (n/10000) scaled by 2^FRAC_BITS, rounded to nearest
    localparam longint G_1136   = ((longint'(1136) << FRAC_BITS) + 5000) / 10000;
    localparam longint G_14062  = ((longint'(14062) << FRAC_BITS) + 5000) / 10000;
    localparam longint G_12142  = ((longint'(12142) << FRAC_BITS) + 5000) / 10000;
    localparam longint G_168    = ((longint'(168) << FRAC_BITS) + 5000) / 10000;
    localparam longint G_85     = ((longint'(85) << FRAC_BITS) + 5000) / 10000;
    localparam longint G_597    = ((longint'(597) << FRAC_BITS) + 5000) / 10000;
    // The velocity coupling is an exact multiple of one LSB after rounding,
    // so it folds into the gain that multiplies the same state element.
    localparam longint G_COUPLE = longint'(COUPLING) << FRAC_BITS;

    localparam logic signed [PROD_W-1:0] DRV_BIAS  = PROD_W'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] STEP_BIAS = PROD_W'(longint'(1) << (DT_BITS - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRV_MUL,
        ST_DRV_ACC,
        ST_STP_RATE,
        ST_STP_MUL,
        ST_STP_ACC,
        ST_STP_UPD,
        ST_FINISH
    } state_t;

    typedef enum logic [0:0] {
        REG_VELOCITY_LIMIT = 1'b0,
        REG_X_REFERENCE    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                       en;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [GAIN_W-1:0]   b;
        logic signed [PROD_W-1:0]   bias;
    } mul_req_t;

    // Row 0 yields u0 - 15*vy, row 1 yields u1 + 15*vx (both negated sums).
    function automatic logic signed [GAIN_W-1:0] gain_of(
        input logic              row,
        input logic [ELEM_W-1:0] col
    );
        logic signed [GAIN_W-1:0] g;
        g = '0;
        if (!row) begin
            unique case (col)
                ELEM_X_POS: g = GAIN_W'(G_1136);
                ELEM_Y_POS: g = GAIN_W'(G_14062);
                ELEM_X_VEL: g = GAIN_W'(G_12142);
                ELEM_Y_VEL: g = GAIN_W'(G_COUPLE - G_168);
                ELEM_X_INT: g = GAIN_W'(G_85);
                ELEM_Y_INT: g = GAIN_W'(G_597);
                default:    g = '0;
            endcase
        end else begin
            unique case (col)
                ELEM_X_POS: g = GAIN_W'(-G_14062);
                ELEM_Y_POS: g = GAIN_W'(G_1136);
                ELEM_X_VEL: g = GAIN_W'(G_168 - G_COUPLE);
                ELEM_Y_VEL: g = GAIN_W'(G_12142);
                ELEM_X_INT: g = GAIN_W'(-G_597);
                ELEM_Y_INT: g = GAIN_W'(G_85);
                default:    g = '0;
            endcase
        end
        return g;
    endfunction

    // Update order: every element is read before it is overwritten.
    function automatic logic [ELEM_W-1:0] step_elem(input logic [ELEM_W-1:0] step);
        logic [ELEM_W-1:0] e;
        unique case (step)
            3'd0:    e = ELEM_X_INT;
            3'd1:    e = ELEM_Y_INT;
            3'd2:    e = ELEM_X_POS;
            3'd3:    e = ELEM_Y_POS;
            3'd4:    e = ELEM_X_VEL;
            3'd5:    e = ELEM_Y_VEL;
            default: e = ELEM_X_POS;
        endcase
        return e;
    endfunction

    // State element that feeds the rate of an element.
    function automatic logic [ELEM_W-1:0] rate_src(input logic [ELEM_W-1:0] elem);
        logic [ELEM_W-1:0] s;
        unique case (elem)
            ELEM_X_POS: s = ELEM_X_VEL;
            ELEM_Y_POS: s = ELEM_Y_VEL;
            ELEM_X_INT: s = ELEM_X_POS;
            ELEM_Y_INT: s = ELEM_Y_POS;
            default:    s = elem;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lqrsv_mul.sv @@
// Shared registered multiplier with rounding bias for the LQR velocity step unit.
// Depends on lqrsv_pkg.
`default_nettype none

module lqrsv_mul (
    input  wire                                   aclk,
    input  lqrsv_pkg::mul_req_t                   req,
    output logic signed [lqrsv_pkg::PROD_W-1:0]   prod
);

    logic signed [lqrsv_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= $signed(req.a) * $signed(req.b) + $signed(req.bias);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/lqr_state_space_velocity_step_unit.sv @@
// One item is in work at a time: s_tready is low from the s_ transfer until the result
// is loaded into the output register, which waits while a held result is not taken.
// All products share the single multiplier: 12 drive and 12 split Euler-step products,
// each a multiply and an accumulate state, plus a rate and an update state per element.
// Reset (aresetn low, synchronous): plant state to zero, registers to their defaults,
// output empty, sequencer idle.
`default_nettype none

module lqr_state_space_velocity_step_unit (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // s_tdata: tick_period [23:0]
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [lqrsv_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: vel_x_cmd [26:0], vel_y_cmd [53:27], zero [55:54]
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [lqrsv_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: limited [0]
    output logic [lqrsv_pkg::M_TUSER_W-1:0]      m_tuser,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [lqrsv_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [lqrsv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lqrsv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int STATE_W = lqrsv_pkg::STATE_W;
    localparam int ELEM_W  = lqrsv_pkg::ELEM_W;
    localparam int ACC_W   = lqrsv_pkg::ACC_W;
    localparam int RATE_W  = lqrsv_pkg::RATE_W;
    localparam int SUM_W   = lqrsv_pkg::SUM_W;
    localparam int MUL_A_W = lqrsv_pkg::MUL_A_W;
    localparam int GAIN_W  = lqrsv_pkg::GAIN_W;
    localparam int SPLIT_W = lqrsv_pkg::SPLIT_W;
    localparam int HI_W    = lqrsv_pkg::HI_W;
    localparam int TICK_W  = lqrsv_pkg::TICK_W;
    localparam int LIMIT_W = lqrsv_pkg::LIMIT_W;
    localparam int XREF_W  = lqrsv_pkg::XREF_W;
    localparam int VEL_W   = lqrsv_pkg::VEL_W;

    lqrsv_pkg::state_t state_reg, state_next;

    logic                       row_reg, row_next;
    logic [ELEM_W-1:0]          idx_reg, idx_next;
    logic [ELEM_W-1:0]          step_reg, step_next;
    logic                       half_reg, half_next;
    logic [TICK_W-1:0]          dt_reg, dt_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [RATE_W-1:0]   rate_reg, rate_next;
    logic signed [RATE_W-1:0]   rate2_reg, rate2_next;
    logic signed [RATE_W-1:0]   rate3_reg, rate3_next;
    logic signed [STATE_W-1:0]  plant_reg [lqrsv_pkg::NUM_ELEM];
    logic signed [STATE_W-1:0]  plant_next [lqrsv_pkg::NUM_ELEM];
    logic [LIMIT_W-1:0]         limit_reg, limit_next;
    logic signed [XREF_W-1:0]   xref_reg, xref_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [lqrsv_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                       limited_reg, limited_next;

    logic [ELEM_W-1:0]          elem;
    logic [ELEM_W-1:0]          rd_addr;
    logic signed [STATE_W-1:0]  x_rd;
    logic                       out_free;
    logic                       cfg_wr;
    logic signed [ACC_W-1:0]    drv_sum;
    logic signed [SUM_W-1:0]    upd_sum;
    logic                       upd_ovf;
    logic signed [STATE_W-1:0]  upd_sat;
    logic signed [MUL_A_W-1:0]  lim_w, nlim_w, vx_w, vy_w;
    logic signed [STATE_W-1:0]  vx_c, vy_c;
    logic                       lim_x, lim_y;
    lqrsv_pkg::mul_req_t        mul_req;
    logic signed [lqrsv_pkg::PROD_W-1:0] prod;

    lqrsv_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    assign s_tready = (state_reg == lqrsv_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = limited_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign out_free = !m_tvalid_reg || m_tready;
    assign elem     = lqrsv_pkg::step_elem(step_reg);

    // Single read port into the plant state
    always_comb begin
        unique case (state_reg)
            lqrsv_pkg::ST_DRV_MUL:  rd_addr = idx_reg;
            lqrsv_pkg::ST_STP_RATE: rd_addr = lqrsv_pkg::rate_src(elem);
            default:                rd_addr = elem;
        endcase
    end

    assign x_rd = plant_reg[rd_addr];

    // Drive accumulation holds the negated sum of rounded products
    assign drv_sum = acc_reg - ACC_W'(prod >>> lqrsv_pkg::FRAC_BITS);

    // Euler update with saturation to the state width
    assign upd_sum = SUM_W'(x_rd) + SUM_W'(acc_reg >>> lqrsv_pkg::DT_BITS);
    assign upd_ovf = (upd_sum[SUM_W-1:STATE_W-1] != {(SUM_W-STATE_W+1){upd_sum[SUM_W-1]}});
    assign upd_sat = !upd_ovf ? upd_sum[STATE_W-1:0] :
                     (upd_sum[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                       : {1'b0, {(STATE_W-1){1'b1}}});

    // Velocity clamp, limit equal to velocity passes untouched
    always_comb begin
        lim_w  = $signed({{(MUL_A_W-LIMIT_W){1'b0}}, limit_reg});
        nlim_w = -lim_w;
        vx_w   = MUL_A_W'(plant_reg[lqrsv_pkg::ELEM_X_VEL]);
        vy_w   = MUL_A_W'(plant_reg[lqrsv_pkg::ELEM_Y_VEL]);
        priority if (vx_w > lim_w) begin
            vx_c  = lim_w[STATE_W-1:0];
            lim_x = 1'b1;
        end else if (vx_w < nlim_w) begin
            vx_c  = nlim_w[STATE_W-1:0];
            lim_x = 1'b1;
        end else begin
            vx_c  = plant_reg[lqrsv_pkg::ELEM_X_VEL];
            lim_x = 1'b0;
        end
        priority if (vy_w > lim_w) begin
            vy_c  = lim_w[STATE_W-1:0];
            lim_y = 1'b1;
        end else if (vy_w < nlim_w) begin
            vy_c  = nlim_w[STATE_W-1:0];
            lim_y = 1'b1;
        end else begin
            vy_c  = plant_reg[lqrsv_pkg::ELEM_Y_VEL];
            lim_y = 1'b0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lqrsv_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lqrsv_pkg::ST_DRV_MUL;
            end
            lqrsv_pkg::ST_DRV_MUL:  state_next = lqrsv_pkg::ST_DRV_ACC;
            lqrsv_pkg::ST_DRV_ACC: begin
                if (row_reg && idx_reg == lqrsv_pkg::LAST_ELEM) begin
                    state_next = lqrsv_pkg::ST_STP_RATE;
                end else begin
                    state_next = lqrsv_pkg::ST_DRV_MUL;
                end
            end
            lqrsv_pkg::ST_STP_RATE: state_next = lqrsv_pkg::ST_STP_MUL;
            lqrsv_pkg::ST_STP_MUL:  state_next = lqrsv_pkg::ST_STP_ACC;
            lqrsv_pkg::ST_STP_ACC: begin
                state_next = half_reg ? lqrsv_pkg::ST_STP_UPD : lqrsv_pkg::ST_STP_MUL;
            end
            lqrsv_pkg::ST_STP_UPD: begin
                state_next = (step_reg == lqrsv_pkg::LAST_STEP) ? lqrsv_pkg::ST_FINISH
                                                                : lqrsv_pkg::ST_STP_RATE;
            end
            lqrsv_pkg::ST_FINISH: begin
                if (out_free) state_next = lqrsv_pkg::ST_IDLE;
            end
            default: state_next = lqrsv_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        row_next      = row_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        half_next     = half_reg;
        dt_next       = dt_reg;
        acc_next      = acc_reg;
        rate_next     = rate_reg;
        rate2_next    = rate2_reg;
        rate3_next    = rate3_reg;
        plant_next    = plant_reg;
        limit_next    = limit_reg;
        xref_next     = xref_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        limited_next  = limited_reg;
        mul_req       = '0;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        unique case (state_reg)
            lqrsv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    dt_next   = s_tdata[TICK_W-1:0];
                    acc_next  = '0;
                    row_next  = 1'b0;
                    idx_next  = '0;
                    step_next = '0;
                    half_next = 1'b0;
                end
            end
            lqrsv_pkg::ST_DRV_MUL: begin
                mul_req.en   = 1'b1;
                mul_req.a    = MUL_A_W'(x_rd);
                mul_req.b    = lqrsv_pkg::gain_of(row_reg, idx_reg);
                mul_req.bias = lqrsv_pkg::DRV_BIAS;
            end
            lqrsv_pkg::ST_DRV_ACC: begin
                if (idx_reg == lqrsv_pkg::LAST_ELEM) begin
                    if (row_reg) begin
                        rate3_next = drv_sum[RATE_W-1:0];
                    end else begin
                        rate2_next = drv_sum[RATE_W-1:0];
                    end
                    acc_next = '0;
                    idx_next = '0;
                    row_next = ~row_reg;
                end else begin
                    acc_next = drv_sum;
                    idx_next = idx_reg + 1'b1;
                end
            end
            lqrsv_pkg::ST_STP_RATE: begin
                half_next = 1'b0;
                unique case (elem)
                    lqrsv_pkg::ELEM_X_VEL: rate_next = rate2_reg;
                    lqrsv_pkg::ELEM_Y_VEL: rate_next = rate3_reg;
                    lqrsv_pkg::ELEM_X_INT: rate_next = RATE_W'(x_rd) - RATE_W'(xref_reg);
                    default:               rate_next = RATE_W'(x_rd);
                endcase
            end
            lqrsv_pkg::ST_STP_MUL: begin
                // Split the rate: low part unsigned first, then the signed high part
                mul_req.en = 1'b1;
                mul_req.b  = $signed({{(GAIN_W-TICK_W){1'b0}}, dt_reg});
                if (half_reg) begin
                    mul_req.a    = $signed({{(MUL_A_W-HI_W){rate_reg[RATE_W-1]}},
                                            rate_reg[RATE_W-1:SPLIT_W]});
                    mul_req.bias = '0;
                end else begin
                    mul_req.a    = $signed({{(MUL_A_W-SPLIT_W){1'b0}},
                                            rate_reg[SPLIT_W-1:0]});
                    mul_req.bias = lqrsv_pkg::STEP_BIAS;
                end
            end
            lqrsv_pkg::ST_STP_ACC: begin
                if (half_reg) begin
                    acc_next = acc_reg + (ACC_W'(prod) <<< SPLIT_W);
                end else begin
                    acc_next  = ACC_W'(prod);
                    half_next = 1'b1;
                end
            end
            lqrsv_pkg::ST_STP_UPD: begin
                plant_next[elem] = upd_sat;
                step_next        = step_reg + 1'b1;
            end
            lqrsv_pkg::ST_FINISH: begin
                if (out_free) begin
                    plant_next[lqrsv_pkg::ELEM_X_VEL] = vx_c;
                    plant_next[lqrsv_pkg::ELEM_Y_VEL] = vy_c;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(lqrsv_pkg::M_TDATA_W-2*VEL_W){1'b0}},
                                     vy_c[VEL_W-1:0], vx_c[VEL_W-1:0]};
                    limited_next  = lim_x | lim_y;
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr) begin
            unique case (lqrsv_pkg::reg_idx_t'(paddr[2]))
                lqrsv_pkg::REG_VELOCITY_LIMIT: limit_next = pwdata[LIMIT_W-1:0];
                lqrsv_pkg::REG_X_REFERENCE:    xref_next  = pwdata[XREF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read
    always_comb begin
        unique case (lqrsv_pkg::reg_idx_t'(paddr[2]))
            lqrsv_pkg::REG_VELOCITY_LIMIT:
                prdata = {{(lqrsv_pkg::APB_DATA_W-LIMIT_W){1'b0}}, limit_reg};
            lqrsv_pkg::REG_X_REFERENCE:
                prdata = {{(lqrsv_pkg::APB_DATA_W-XREF_W){xref_reg[XREF_W-1]}}, xref_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lqrsv_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            limit_reg    <= lqrsv_pkg::LIMIT_RESET;
            xref_reg     <= lqrsv_pkg::XREF_RESET;
            row_reg      <= 1'b0;
            idx_reg      <= '0;
            step_reg     <= '0;
            half_reg     <= 1'b0;
            for (int i = 0; i < lqrsv_pkg::NUM_ELEM; i++) begin
                plant_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            limit_reg    <= limit_next;
            xref_reg     <= xref_next;
            row_reg      <= row_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            half_reg     <= half_next;
            plant_reg    <= plant_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg      <= dt_next;
        acc_reg     <= acc_next;
        rate_reg    <= rate_next;
        rate2_reg   <= rate2_next;
        rate3_reg   <= rate3_next;
        m_tdata_reg <= m_tdata_next;
        limited_reg <= limited_next;
    end

endmodule

`default_nettype wire

@@ rtl/lqrsv_checker.sv @@
// Port-level checker for the LQR velocity step unit, bound to the top level.
// Depends on lqrsv_pkg and lqr_state_space_velocity_step_unit.
`default_nettype none

module lqrsv_checker (
    input wire                                  aclk,
    input wire                                  aresetn,
    input wire                                  s_tvalid,
    input wire                                  s_tready,
    input wire [lqrsv_pkg::S_TDATA_W-1:0]       s_tdata,
    input wire                                  m_tvalid,
    input wire                                  m_tready,
    input wire [lqrsv_pkg::M_TDATA_W-1:0]       m_tdata,
    input wire [lqrsv_pkg::M_TUSER_W-1:0]       m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // A new result only comes out of a busy period
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work");

    // Reset empties the output and idles the sequencer
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear output and sequencer");

endmodule

bind lqr_state_space_velocity_step_unit lqrsv_checker u_lqrsv_checker (.*);

`default_nettype wire
